>>> hdl/assert_macros.svh
// Assertion macros shared by the envelope valley segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/evs_pkg.sv
// Types and constants for the envelope valley segmenter.
package evs_pkg;

  localparam int MAX_LENGTH  = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int IDX_W       = 16;

  // Index saturation point: min(MAX_LENGTH-1, 2^IDX_W-1)
  localparam int IDX_CAP_INT = ((MAX_LENGTH - 1) > ((1 << IDX_W) - 1)) ?
                               ((1 << IDX_W) - 1) : (MAX_LENGTH - 1);
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);

  // Result queue
  localparam int MAX_PUSH   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [MAG_W-1:0] magnitude;
    logic             last;
  } result_t;

  // Up to three results from one item, in order of slot 0, 1, 2
  typedef struct packed {
    logic [MAX_PUSH-1:0]             valid;
    result_t [MAX_PUSH-1:0]          res;
  } push_t;

endpackage

>>> hdl/evs_detect.sv
// Peak and valley detection state and per-item result generation.
`include "assert_macros.svh"

module evs_detect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                proc_i,
  input  logic signed [evs_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                last_sample_i,
  output evs_pkg::push_t                      push_o
);

  localparam logic [1:0] PCNT_NONE = 2'd0;
  localparam logic [1:0] PCNT_ONE  = 2'd1;
  localparam logic [1:0] PCNT_MANY = 2'd2;

  logic [evs_pkg::IDX_W-1:0] scnt_q, scnt_d;
  logic [evs_pkg::MAG_W-1:0] pmag_q, pmag_d;
  logic                      srise_q, srise_d;
  logic [evs_pkg::IDX_W-1:0] ppi_q, ppi_d;
  logic [evs_pkg::MAG_W-1:0] ppm_q, ppm_d;
  logic                      prise_q, prise_d;
  logic [1:0]                pcnt_q, pcnt_d;

  logic [evs_pkg::SAMPLE_BITS-1:0] neg;
  logic [evs_pkg::MAG_W-1:0]       mag;
  logic                            first;
  logic [evs_pkg::IDX_W-1:0]       cur;
  logic                            rise;
  logic                            peak_a;
  logic                            rise_a, rise_b;
  logic                            emit_a, emit_b;
  // Peak stage after the (optional) interior peak
  logic [evs_pkg::IDX_W-1:0]       ppi1;
  logic [evs_pkg::MAG_W-1:0]       ppm1;
  logic                            prise1;
  logic [1:0]                      pcnt1;

  // Magnitude with saturation of the most negative code
  always_comb begin
    neg = ~sample_i + 1'b1;
    if (sample_i[evs_pkg::SAMPLE_BITS-1]) begin
      mag = neg[evs_pkg::SAMPLE_BITS-1] ? '1 : neg[evs_pkg::MAG_W-1:0];
    end else begin
      mag = sample_i[evs_pkg::MAG_W-1:0];
    end
  end

  // Step compares and peak/valley decisions
  always_comb begin
    first  = (pcnt_q == PCNT_NONE);
    cur    = (scnt_q == evs_pkg::IDX_CAP) ? evs_pkg::IDX_CAP : scnt_q + 1'b1;
    rise   = (mag > pmag_q);
    peak_a = (scnt_q != '0) && srise_q && !rise;

    // Previous sample turned out to be a peak
    rise_a = (pmag_q > ppm_q);
    emit_a = peak_a && (pcnt_q == PCNT_MANY) && !prise_q && rise_a;
    if (peak_a) begin
      ppi1   = scnt_q;
      ppm1   = pmag_q;
      prise1 = rise_a;
      pcnt1  = PCNT_MANY;
    end else begin
      ppi1   = ppi_q;
      ppm1   = ppm_q;
      prise1 = prise_q;
      pcnt1  = pcnt_q;
    end

    // Final sample is always a peak
    rise_b = (mag > ppm1);
    emit_b = last_sample_i && (pcnt1 == PCNT_MANY) && !prise1 && rise_b;
  end

  // Result slots and next state
  always_comb begin
    push_o = '0;
    scnt_d  = scnt_q;
    pmag_d  = pmag_q;
    srise_d = srise_q;
    ppi_d   = ppi_q;
    ppm_d   = ppm_q;
    prise_d = prise_q;
    pcnt_d  = pcnt_q;

    if (proc_i) begin
      if (first) begin
        push_o.valid[2]         = 1'b1;
        push_o.res[2].index     = '0;
        push_o.res[2].magnitude = mag;
        push_o.res[2].last      = last_sample_i;
        if (last_sample_i) begin
          scnt_d  = '0;
          pmag_d  = '0;
          srise_d = 1'b0;
          ppi_d   = '0;
          ppm_d   = '0;
          prise_d = 1'b0;
          pcnt_d  = PCNT_NONE;
        end else begin
          scnt_d  = '0;
          pmag_d  = mag;
          srise_d = 1'b0;
          ppi_d   = '0;
          ppm_d   = mag;
          prise_d = 1'b0;
          pcnt_d  = PCNT_ONE;
        end
      end else begin
        push_o.valid[0]         = emit_a;
        push_o.res[0].index     = ppi_q;
        push_o.res[0].magnitude = ppm_q;
        push_o.res[0].last      = 1'b0;
        if (last_sample_i) begin
          push_o.valid[1]         = emit_b;
          push_o.res[1].index     = ppi1;
          push_o.res[1].magnitude = ppm1;
          push_o.res[1].last      = 1'b0;
          push_o.valid[2]         = 1'b1;
          push_o.res[2].index     = cur;
          push_o.res[2].magnitude = mag;
          push_o.res[2].last      = 1'b1;
          scnt_d  = '0;
          pmag_d  = '0;
          srise_d = 1'b0;
          ppi_d   = '0;
          ppm_d   = '0;
          prise_d = 1'b0;
          pcnt_d  = PCNT_NONE;
        end else begin
          scnt_d  = cur;
          pmag_d  = mag;
          srise_d = rise;
          ppi_d   = ppi1;
          ppm_d   = ppm1;
          prise_d = prise1;
          pcnt_d  = pcnt1;
        end
      end
    end
  end

  // Detection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q  <= '0;
      pmag_q  <= '0;
      srise_q <= 1'b0;
      ppi_q   <= '0;
      ppm_q   <= '0;
      prise_q <= 1'b0;
      pcnt_q  <= PCNT_NONE;
    end else begin
      scnt_q  <= scnt_d;
      pmag_q  <= pmag_d;
      srise_q <= srise_d;
      ppi_q   <= ppi_d;
      ppm_q   <= ppm_d;
      prise_q <= prise_d;
      pcnt_q  <= pcnt_d;
    end
  end

  `ASSERT_IMPLIES(a_first_one_result, clk_i, rst_ni, proc_i && first, push_o.valid == 3'b100, "first item of a sequence must give exactly one result")
  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, proc_i && last_sample_i, pcnt_q == PCNT_NONE && scnt_q == '0, "state not cleared after last item")
  `ASSERT_IMPLIES(a_last_closes, clk_i, rst_ni, proc_i && last_sample_i, push_o.valid[2] && push_o.res[2].last, "last item must close the sequence")

endmodule

>>> hdl/evs_result_fifo.sv
// Result queue: takes up to three results per cycle, delivers one per cycle while pop_i is high.
`include "assert_macros.svh"

module evs_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  evs_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             nonempty_o,
  output evs_pkg::result_t head_o
);

  evs_pkg::result_t mem_q [evs_pkg::FIFO_DEPTH];

  logic [evs_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [evs_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [evs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [evs_pkg::PTR_W-1:0] slot [evs_pkg::MAX_PUSH];
  logic [evs_pkg::CNT_W-1:0] npush;
  logic                      pop;

  // Compact valid slots onto consecutive queue entries
  always_comb begin
    slot[0] = wr_ptr_q;
    slot[1] = wr_ptr_q + evs_pkg::PTR_W'(push_i.valid[0]);
    slot[2] = slot[1] + evs_pkg::PTR_W'(push_i.valid[1]);
    npush   = evs_pkg::CNT_W'(push_i.valid[0]) + evs_pkg::CNT_W'(push_i.valid[1])
            + evs_pkg::CNT_W'(push_i.valid[2]);
    pop      = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q + npush[evs_pkg::PTR_W-1:0];
    rd_ptr_d = rd_ptr_q + evs_pkg::PTR_W'(pop);
    cnt_d    = cnt_q + npush - evs_pkg::CNT_W'(pop);
  end

  assign room_o     = (cnt_q <= evs_pkg::CNT_W'(evs_pkg::FIFO_DEPTH - evs_pkg::MAX_PUSH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < evs_pkg::MAX_PUSH; i++) begin
      if (push_i.valid[i]) begin
        mem_q[slot[i]] <= push_i.res[i];
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= evs_pkg::CNT_W'(evs_pkg::FIFO_DEPTH), "result queue overfilled")
  `ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push_i.valid != '0, room_o, "results pushed without room")

endmodule

>>> hdl/envelope_valley_segmenter.sv
// Top level of the envelope valley segmenter: input register, detector, result queue.
// An accepted item passes the input register, then the result queue, to the outputs.
// Throughput: one item per cycle while the result queue holds at most five results;
//   an item may yield up to three results, delivered one per cycle while not stalled.
// The input stalls only when the queue lacks room for three more results.
// Reset (rst_ni, async, active low) empties the queue and starts a new sequence.
`include "assert_macros.svh"

module envelope_valley_segmenter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [evs_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [evs_pkg::IDX_W-1:0]              boundary_index_o,
  output logic [evs_pkg::MAG_W-1:0]              boundary_magnitude_o,
  output logic                                   last_boundary_o
);

  logic                                   in_vld_q;
  logic signed [evs_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                   last_q;
  logic                                   room;
  logic                                   proc;
  logic                                   in_accept;
  evs_pkg::push_t                         push;
  evs_pkg::result_t                       head;

  assign proc       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
      last_q   <= last_sample_i;
    end
  end

  evs_detect u_detect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .proc_i        (proc),
    .sample_i      (sample_q),
    .last_sample_i (last_q),
    .push_o        (push)
  );

  evs_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (!out_stall_i),
    .room_o     (room),
    .nonempty_o (out_valid_o),
    .head_o     (head)
  );

  assign boundary_index_o     = head.index;
  assign boundary_magnitude_o = head.magnitude;
  assign last_boundary_o      = head.last;

  `ASSERT_NEXT(a_held_item, clk_i, rst_ni, in_stall_o, in_vld_q, "held input item lost")

endmodule

>>> sim/envelope_valley_segmenter_test.sv
// Self-checking testbench for the envelope valley segmenter: random stalls, valley prediction.
module envelope_valley_segmenter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import evs_pkg::*;

  localparam int LIMIT_CYCLES = 20_000;
  localparam int RANDOM_ITEMS = 236;
  localparam int SETTLE       = 16;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
    logic                          drain;  // hold off until all boundaries are out
  } sample_item_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i      = '0;
  logic                          last_sample_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [IDX_W-1:0]              boundary_index_o;
  logic [MAG_W-1:0]              boundary_magnitude_o;
  logic                          last_boundary_o;

  sample_item_t sample_feed[$];
  result_t      pending_boundaries[$];
  int           errors    = 0;
  int           cycles    = 0;
  logic         took_item = 1'b0;
  logic         calm;

  // Detector state of the predictor
  logic [IDX_W-1:0] sample_index;
  logic [MAG_W-1:0] prior_magnitude;
  logic             was_rising;
  logic [IDX_W-1:0] peak_index;
  logic [MAG_W-1:0] peak_magnitude;
  logic             peaks_rising;
  logic [1:0]       peaks_seen = '0;

  envelope_valley_segmenter dut (.*);

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // A stretch of cycles where neither side idles
  assign calm = (cycles >= 150) && (cycles < 320);

  function automatic logic [MAG_W-1:0] sample_magnitude(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic [SAMPLE_BITS-1:0] flipped;
    flipped = s[SAMPLE_BITS-1] ? -s : s;
    // only the most negative sample keeps its top bit: saturate it
    if (flipped[SAMPLE_BITS-1]) return '1;
    return flipped[MAG_W-1:0];
  endfunction

  task automatic push_boundary(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] mag,
                               input logic last);
    result_t r;
    r.index     = idx;
    r.magnitude = mag;
    r.last      = last;
    pending_boundaries = {pending_boundaries, r};
  endtask

  task automatic clear_detector();
    sample_index    = '0;
    prior_magnitude = '0;
    was_rising      = 1'b0;
    peak_index      = '0;
    peak_magnitude  = '0;
    peaks_rising    = 1'b0;
    peaks_seen      = '0;
  endtask

  // Valley stage: a new peak may reveal the previous one as a valley
  task automatic take_peak(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] mag);
    logic up;
    up = mag > peak_magnitude;
    if (peaks_seen >= 2'd2) begin
      if (!peaks_rising && up) push_boundary(peak_index, peak_magnitude, 1'b0);
    end else begin
      peaks_seen = 2'd2;
    end
    peaks_rising   = up;
    peak_index     = idx;
    peak_magnitude = mag;
  endtask

  task automatic predict_boundaries(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    logic [MAG_W-1:0] mag;
    logic [IDX_W-1:0] pos;
    logic             up;
    mag = sample_magnitude(s);
    if (peaks_seen == 2'd0) begin
      // first sample of a sequence is always a boundary
      push_boundary('0, mag, last);
      if (last) begin
        clear_detector();
      end else begin
        sample_index    = '0;
        prior_magnitude = mag;
        was_rising      = 1'b0;
        peak_index      = '0;
        peak_magnitude  = mag;
        peaks_rising    = 1'b0;
        peaks_seen      = 2'd1;
      end
    end else begin
      pos = (sample_index >= IDX_CAP) ? IDX_CAP : sample_index + 1'b1;
      up  = mag > prior_magnitude;
      if (sample_index != '0 && was_rising && !up) take_peak(sample_index, prior_magnitude);
      was_rising = up;
      if (last) begin
        take_peak(pos, mag);
        push_boundary(pos, mag, 1'b1);
        clear_detector();
      end else begin
        prior_magnitude = mag;
        sample_index    = pos;
      end
    end
  endtask

  task automatic report_error(input string text);
    errors++;
    if (errors <= 10) $display("%s", text);
  endtask

  // Accepted samples feed the predictor; accepted boundaries are checked
  always @(posedge clk_i) begin : watch
    result_t want;
    took_item = rst_ni && in_valid_i && !in_stall_o;
    if (took_item) predict_boundaries(sample_i, last_sample_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_boundaries.size() == 0) begin
        report_error($sformatf("ERROR: unexpected boundary idx=%0d mag=%0d last=%0b",
                               boundary_index_o, boundary_magnitude_o, last_boundary_o));
      end else begin
        want = pending_boundaries.pop_front();
        if (want.index !== boundary_index_o || want.magnitude !== boundary_magnitude_o ||
            want.last !== last_boundary_o)
          report_error($sformatf(
            "ERROR: boundary expected idx=%0d mag=%0d last=%0b, got idx=%0d mag=%0d last=%0b",
            want.index, want.magnitude, want.last,
            boundary_index_o, boundary_magnitude_o, last_boundary_o));
      end
    end
  end

  // Sample driver with random gaps and drain points
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_item)) begin
      if (sample_feed.size() == 0 ||
          (sample_feed[0].drain && pending_boundaries.size() != 0) ||
          (!calm && $urandom_range(99) < 10)) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i    <= 1'b1;
        sample_i      <= sample_feed[0].value;
        last_sample_i <= sample_feed[0].last;
        void'(sample_feed.pop_front());
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < 10);
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (rst_ni) cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last,
                            input logic drain);
    sample_item_t it;
    it.value = value;
    it.last  = last;
    it.drain = drain;
    sample_feed = {sample_feed, it};
  endtask

  initial begin
    int produced;
    int seq_no;
    int len;
    int style;
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS-1:0] value;

    // Directed: single and two-sample sequences
    add_sample(24'sd0, 1'b1, 1'b1);
    add_sample(MOST_NEG, 1'b1, 1'b0);
    add_sample(24'sd5, 1'b0, 1'b0);
    add_sample(-24'sd7, 1'b1, 1'b0);
    // a valley between two peaks, with signed samples
    add_sample(24'sd10, 1'b0, 1'b0);
    add_sample(-24'sd50, 1'b0, 1'b0);
    add_sample(24'sd20, 1'b0, 1'b0);
    add_sample(-24'sd40, 1'b0, 1'b0);
    add_sample(24'sd30, 1'b0, 1'b0);
    add_sample(24'sd60, 1'b1, 1'b0);
    // extremes, the most negative one saturating
    add_sample(MOST_NEG, 1'b0, 1'b1);
    add_sample(MOST_POS, 1'b0, 1'b0);
    add_sample(-MOST_POS, 1'b0, 1'b0);
    add_sample(24'sd0, 1'b0, 1'b0);
    add_sample(MOST_POS, 1'b1, 1'b0);
    // flat steps do not count as rises
    add_sample(24'sd3, 1'b0, 1'b0);
    add_sample(-24'sd3, 1'b0, 1'b0);
    add_sample(24'sd3, 1'b1, 1'b0);
    add_sample(24'sd1, 1'b0, 1'b0);
    add_sample(24'sd4, 1'b0, 1'b0);
    add_sample(-24'sd4, 1'b0, 1'b0);
    add_sample(24'sd2, 1'b0, 1'b0);
    add_sample(24'sd9, 1'b1, 1'b0);

    // Random sequences of mixed shape
    produced = 0;
    seq_no   = 0;
    while (produced < RANDOM_ITEMS) begin
      len   = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      style = $urandom_range(3);
      base  = SAMPLE_BITS'($urandom);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: value = SAMPLE_BITS'($urandom);
          1: value = SAMPLE_BITS'($signed($urandom_range(6)) - 3);
          2: begin
            base  = SAMPLE_BITS'(base + $signed($urandom_range(40)) - 20);
            value = base;
          end
          default: begin
            case ($urandom_range(4))
              0: value = MOST_NEG;
              1: value = MOST_POS;
              2: value = -MOST_POS;
              3: value = '0;
              default: value = SAMPLE_BITS'($urandom);
            endcase
          end
        endcase
        add_sample(value, i == len - 1, i == 0 && seq_no % 8 == 3);
      end
      produced += len;
      seq_no++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (sample_feed.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_boundaries.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/evs_pkg.sv
hdl/evs_detect.sv
hdl/evs_result_fifo.sv
hdl/envelope_valley_segmenter.sv
sim/envelope_valley_segmenter_test.sv
